// File: src/qam16_pkg.sv
// Shared constants, types and the quarter-wave sine table for the 16-QAM byte modulator.
// No dependencies; used by qam16_mapper, qam16_byte_modulator and qam16_checker.
package qam16_pkg;

  localparam int SYM_SAMPLES      = 20;
  localparam int TABLE_INDEX_BITS = 10;

  localparam int PHASE_W    = 16;
  localparam int SAMPLE_W   = 18;
  localparam int AMP_W      = 15;
  localparam int WAVE_W     = AMP_W + 1;
  localparam int QUARTER    = (1 << TABLE_INDEX_BITS) / 4;
  localparam int QIDX_W     = TABLE_INDEX_BITS - 1;
  localparam int CNT_W      = (SYM_SAMPLES > 1) ? $clog2(SYM_SAMPLES) : 1;

  localparam logic [PHASE_W-1:0] PHASE_STEP_RESET = 16'd3277;
  localparam logic [63:0]        TWO_PI_Q30       = 64'd6746518852;

  typedef logic [AMP_W-1:0] qsine_tab_t [0:QUARTER];

  // Quarter-wave sine in Q1.14, built at elaboration from a Taylor series in Q30.
  function automatic qsine_tab_t build_qsine();
    qsine_tab_t         tab;
    logic [63:0]        x;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic [63:0]        r;
    for (int m = 0; m <= QUARTER; m++) begin
      x    = (64'(m) * TWO_PI_Q30 + 64'((1 << TABLE_INDEX_BITS) / 2)) >> TABLE_INDEX_BITS;
      term = x;
      sum  = $signed(x);
      term = (term * x) >> 30;
      term = ((term * x) >> 30) / 64'd6;
      sum  = sum - $signed(term);
      term = (term * x) >> 30;
      term = ((term * x) >> 30) / 64'd20;
      sum  = sum + $signed(term);
      term = (term * x) >> 30;
      term = ((term * x) >> 30) / 64'd42;
      sum  = sum - $signed(term);
      term = (term * x) >> 30;
      term = ((term * x) >> 30) / 64'd72;
      sum  = sum + $signed(term);
      term = (term * x) >> 30;
      term = ((term * x) >> 30) / 64'd110;
      sum  = sum - $signed(term);
      term = (term * x) >> 30;
      term = ((term * x) >> 30) / 64'd156;
      sum  = sum + $signed(term);
      if (sum < 0) begin
        sum = '0;
      end
      r = ($unsigned(sum) + 64'd32768) >> 16;
      if (r > 64'd16384) begin
        r = 64'd16384;
      end
      tab[m] = AMP_W'(r);
    end
    return tab;
  endfunction

  localparam qsine_tab_t QSINE = build_qsine();

endpackage

// File: src/qam16_mapper.sv
// Combinational symbol mapper: one 16-QAM nibble and a carrier phase to one passband sample.
// Depends on qam16_pkg for the sine table and widths.
module qam16_mapper (
  input  logic [3:0]                              nibble,
  input  logic [qam16_pkg::PHASE_W-1:0]           phase,
  output logic signed [qam16_pkg::SAMPLE_W-1:0]   sample
);

  localparam int TIB = qam16_pkg::TABLE_INDEX_BITS;

  logic [TIB-1:0]                           k;
  logic [1:0]                               q_cos;
  logic signed [qam16_pkg::WAVE_W-1:0]      sin_v;
  logic signed [qam16_pkg::WAVE_W-1:0]      cos_v;
  logic signed [qam16_pkg::WAVE_W:0]        i_term;
  logic signed [qam16_pkg::WAVE_W:0]        q_term;

  // Full-wave sine from the quarter table: odd quadrants mirror, upper half negates.
  function automatic logic signed [qam16_pkg::WAVE_W-1:0] wave(
    input logic [1:0]     q,
    input logic [TIB-3:0] r
  );
    logic [qam16_pkg::QIDX_W-1:0] m;
    logic [qam16_pkg::AMP_W-1:0]  v;
    m = q[0] ? (qam16_pkg::QIDX_W'(qam16_pkg::QUARTER) - {1'b0, r}) : {1'b0, r};
    v = qam16_pkg::QSINE[m];
    return q[1] ? -$signed({1'b0, v}) : $signed({1'b0, v});
  endfunction

  // Level per bit pair: 00 -> -3, 01 -> -1, 10 -> +3, 11 -> +1.
  function automatic logic signed [qam16_pkg::WAVE_W:0] scale(
    input logic [1:0]                          pair,
    input logic signed [qam16_pkg::WAVE_W-1:0] v
  );
    logic signed [qam16_pkg::WAVE_W:0] w;
    logic signed [qam16_pkg::WAVE_W:0] t;
    w = {v[qam16_pkg::WAVE_W-1], v};
    t = pair[0] ? w : ((w <<< 1) + w);
    return pair[1] ? t : -t;
  endfunction

  assign k     = phase[qam16_pkg::PHASE_W-1 -: TIB];
  assign q_cos = k[TIB-1:TIB-2] + 2'd1;
  assign sin_v = wave(k[TIB-1:TIB-2], k[TIB-3:0]);
  assign cos_v = wave(q_cos, k[TIB-3:0]);

  assign i_term = scale(nibble[3:2], cos_v);
  assign q_term = scale(nibble[1:0], sin_v);
  assign sample = {i_term[qam16_pkg::WAVE_W], i_term} + {q_term[qam16_pkg::WAVE_W], q_term};

endmodule

// File: src/qam16_byte_modulator.sv
// 16-QAM byte modulator: the word sequencer and the output register.
// Depends on qam16_pkg and instantiates qam16_mapper.
//
// Usage:
//   Input channel (in_valid / in_stall / data_byte): one word is one message byte.
//   Output channel (out_valid / out_stall / sample, second_symbol, last): one word is
//   one Q3.14 passband sample. Each byte yields 2 * SYM_SAMPLES words (40),
//   the upper nibble symbol first; last marks the final word of the byte.
//   Configuration channel (cfg_valid / cfg_ready / cfg_data): writes phase_step;
//   cfg_ready is always high. Write it only while the block is idle.
// Timing: an accepted byte is held in the sequencer, and its first sample is registered
//   into the output register, raising out_valid, once that register is free.
//   Throughput: one sample per cycle while out_stall does not hold the output;
//   the sequencer accepts the next byte in the cycle its last sample moves into the
//   output register, so bytes stream with no gap between them.
// Stall: while out_stall is high and out_valid is set, the output word holds and the sequencer waits; the
//   input channel stalls until the current byte's final sample has been taken in.
// Reset (rst, synchronous): empties the sequencer and the output register and sets
//   phase_step to 3277.
module qam16_byte_modulator (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [7:0]                             data_byte,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [qam16_pkg::SAMPLE_W-1:0]  sample,
  output logic                                   second_symbol,
  output logic                                   last,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [qam16_pkg::PHASE_W-1:0]          cfg_data
);

  localparam logic [qam16_pkg::CNT_W-1:0] CNT_LAST =
    qam16_pkg::CNT_W'(qam16_pkg::SYM_SAMPLES - 1);

  logic [qam16_pkg::PHASE_W-1:0]          phase_step;
  logic                                   gen_valid;
  logic [7:0]                             gen_byte;
  logic                                   gen_sym;
  logic [qam16_pkg::CNT_W-1:0]            gen_cnt;
  logic [qam16_pkg::PHASE_W-1:0]          gen_phase;

  logic                                   out_load;
  logic                                   sym_end;
  logic                                   gen_end;
  logic                                   in_take;
  logic [3:0]                             nibble;
  logic signed [qam16_pkg::SAMPLE_W-1:0]  sample_next;

  assign cfg_ready = 1'b1;

  assign out_load = gen_valid && (!out_valid || !out_stall);
  assign sym_end  = (gen_cnt == CNT_LAST);
  assign gen_end  = gen_sym && sym_end;
  assign in_stall = gen_valid && !(out_load && gen_end);
  assign in_take  = in_valid && !in_stall;
  assign nibble   = gen_sym ? gen_byte[3:0] : gen_byte[7:4];

  qam16_mapper u_mapper (
    .nibble (nibble),
    .phase  (gen_phase),
    .sample (sample_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step <= qam16_pkg::PHASE_STEP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      phase_step <= cfg_data;
    end
  end

  // Sequencer: walks both symbols of the held byte, one sample per output load.
  always_ff @(posedge clk) begin
    if (rst) begin
      gen_valid <= 1'b0;
    end else if (in_take) begin
      gen_valid <= 1'b1;
      gen_byte  <= data_byte;
      gen_sym   <= 1'b0;
      gen_cnt   <= '0;
      gen_phase <= '0;
    end else if (out_load) begin
      if (gen_end) begin
        gen_valid <= 1'b0;
      end else if (sym_end) begin
        gen_sym   <= 1'b1;
        gen_cnt   <= '0;
        gen_phase <= '0;
      end else begin
        gen_cnt   <= gen_cnt + 1'b1;
        gen_phase <= gen_phase + phase_step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid     <= 1'b1;
      sample        <= sample_next;
      second_symbol <= gen_sym;
      last          <= gen_end;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// File: src/qam16_checker.sv
// Port-level checker for the 16-QAM byte modulator, bound to the top level.
// Depends on qam16_pkg for the sample width.
module qam16_checker (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  in_valid,
  input logic                                  in_stall,
  input logic                                  out_valid,
  input logic                                  out_stall,
  input logic signed [qam16_pkg::SAMPLE_W-1:0] sample,
  input logic                                  second_symbol,
  input logic                                  last
);

  // A stalled output word stays valid and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(sample) && $stable(second_symbol)
      && $stable(last))
    else $error("stalled output word changed");

  // A byte just taken in keeps the input side stalled on the next cycle.
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled right after a byte was taken");

  // Within the lower nibble symbol, the next word is still of that symbol.
  a_second_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && second_symbol && !last |=> !out_valid || second_symbol)
    else $error("second symbol ended before its last word");

  // After the last word of a byte, the next word starts a symbol at zero phase.
  a_new_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && last |=> !out_valid || (!second_symbol &&
      (sample == 18'sd16384 || sample == -18'sd16384 ||
       sample == 18'sd49152 || sample == -18'sd49152)))
    else $error("word after last is not the zero-phase start of a new byte");

endmodule

bind qam16_byte_modulator qam16_checker u_qam16_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .sample        (sample),
  .second_symbol (second_symbol),
  .last          (last)
);
